// ----- sv/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and codes shared by the link round-trip probe.
// ----------------------------------------------------------------------------
package lpe_pkg;

    // item function codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_FRAME = 3'd1;
    localparam logic [2:0] FUNC_TXOUT = 3'd2;
    localparam logic [2:0] FUNC_DELIV = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    // frame kind byte
    localparam logic [7:0] KIND_PING = 8'd1;
    localparam logic [7:0] KIND_PONG = 8'd2;

    // frame to transmit
    localparam logic [1:0] TX_NONE = 2'd0;
    localparam logic [1:0] TX_PING = 2'd1;
    localparam logic [1:0] TX_PONG = 2'd2;

    // station role
    localparam logic [1:0] ROLE_PING = 2'd1;
    localparam logic [1:0] ROLE_ECHO = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RADIO_READY = 3'd0;
    localparam logic [2:0] REG_ROLE        = 3'd1;
    localparam logic [2:0] REG_RUNNING     = 3'd2;
    localparam logic [2:0] REG_PEER_ADDR   = 3'd3;
    localparam logic [2:0] REG_PEER_VALID  = 3'd4;
    localparam logic [2:0] REG_PING_PERIOD = 3'd5;

    localparam logic [7:0]  FRAME_LEN_OK = 8'd5;
    localparam logic [19:0] PERIOD_RESET = 20'd1000;

    typedef struct packed {
        logic [2:0]  func;
        logic [47:0] now_us;
        logic [47:0] src_addr;
        logic [7:0]  frame_len;
        logic [7:0]  pkt_kind;
        logic [31:0] pkt_seq;
        logic        ok;
    } item_t;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [31:0] tx_seq;
        logic [31:0] sent_count;
        logic [31:0] pong_count;
        logic [31:0] fail_count;
        logic [31:0] echo_rx_count;
        logic [31:0] echo_tx_count;
        logic [31:0] ignored_count;
        logic [31:0] rtt_last;
        logic [31:0] rtt_min;
        logic [31:0] rtt_max;
        logic [47:0] rtt_sum;
    } result_t;

    typedef struct packed {
        logic        used;
        logic [31:0] seq;
        logic [47:0] stamp;
    } slot_t;

endpackage

// ----- sv/link_ping_echo_rtt_probe.sv -----
// ----------------------------------------------------------------------------
// link_ping_echo_rtt_probe
// Round-trip probe for a point-to-point radio link: ping/echo control,
// outstanding-ping slot table and round-trip statistics.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless held by the sweep, a pending clear or result
// back-pressure, and returns one result word per item through the index stage,
// slot-table stage and result register. The outstanding pings live in a
// single-port-write, registered-read slot memory; each item reads its slot in
// the index stage and writes it back in the following stage, with a bypass for
// the write landing on the same edge as the read. After reset and after every
// clear-statistics word the slot table is swept, one entry per cycle; no words
// are accepted during the sweep (register writes still are).
module link_ping_echo_rtt_probe
    import lpe_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,

    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [32:0] RECIP = 33'((65'd1 << (32 + AW)) / SLOT_COUNT);
    localparam logic [AW:0] NMOD = (AW + 1)'(SLOT_COUNT);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    // ---------------- configuration ----------------
    logic        radio_ready_reg;
    logic [1:0]  role_reg;
    logic        running_reg;
    logic [47:0] peer_addr_reg;
    logic        peer_valid_reg;
    logic [19:0] ping_period_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radio_ready_reg <= 1'b0;
            role_reg        <= 2'd0;
            running_reg     <= 1'b0;
            peer_addr_reg   <= 48'd0;
            peer_valid_reg  <= 1'b0;
            ping_period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_RADIO_READY: radio_ready_reg <= pwdata[0];
                REG_ROLE:        role_reg        <= pwdata[1:0];
                REG_RUNNING:     running_reg     <= pwdata[0];
                REG_PEER_ADDR:   peer_addr_reg   <= pwdata[47:0];
                REG_PEER_VALID:  peer_valid_reg  <= pwdata[0];
                REG_PING_PERIOD: ping_period_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_RADIO_READY: prdata = 64'(radio_ready_reg);
            REG_ROLE:        prdata = 64'(role_reg);
            REG_RUNNING:     prdata = 64'(running_reg);
            REG_PEER_ADDR:   prdata = 64'(peer_addr_reg);
            REG_PEER_VALID:  prdata = 64'(peer_valid_reg);
            REG_PING_PERIOD: prdata = 64'(ping_period_reg);
            default:         prdata = 64'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic          s0_valid_reg;
    item_t         s0_item_reg;
    logic [AW:0]   s0_q_reg;
    logic          s1_valid_reg;
    item_t         s1_item_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic          sweep_reg;
    logic [AW-1:0] sweep_idx_reg;

    logic          s1_adv;
    logic          s0_move;
    logic          accept;
    logic          clr_block;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign s0_move   = s0_valid_reg && !sweep_reg && (!s1_valid_reg || s1_adv);
    assign clr_block = (s0_valid_reg && s0_item_reg.func == FUNC_CLEAR) ||
                       (s1_valid_reg && s1_item_reg.func == FUNC_CLEAR);
    assign item_ready = !sweep_reg && !clr_block && (!s0_valid_reg || s0_move);
    assign accept     = item_valid && item_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // seq mod SLOT_COUNT: reciprocal estimate here, one-step correction in s0
    logic [64:0] prod;
    assign prod = 65'(item.pkt_seq) * 65'(RECIP);

    logic [AW:0]   qn;
    logic [AW:0]   r_est;
    logic [AW-1:0] rd_idx;

    always_comb
    begin
        qn     = s0_q_reg * NMOD;
        r_est  = s0_item_reg.pkt_seq[AW:0] - qn;
        rd_idx = (r_est >= NMOD) ? AW'(r_est - NMOD) : AW'(r_est);
    end

    // ---------------- slot memory ----------------
    slot_t         slot_mem [SLOT_COUNT];
    slot_t         rd_data_reg;
    slot_t         fwd_data_reg;
    logic          fwd_hit_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data;
    logic          s1_wr;
    logic [AW-1:0] s1_wr_addr;
    slot_t         s1_wr_data;

    always_comb
    begin
        if (sweep_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_adv && s1_wr;
            wr_addr = s1_wr_addr;
            wr_data = s1_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (s0_move)
        begin
            rd_data_reg  <= slot_mem[rd_idx];
            fwd_data_reg <= wr_data;
            s1_idx_reg   <= rd_idx;
        end
    end

    // ---------------- statistics state ----------------
    logic [31:0]   next_seq_reg,  next_seq_next;
    logic [AW-1:0] next_idx_reg,  next_idx_next;
    logic [47:0]   last_ping_reg, last_ping_next;
    logic          last_vld_reg,  last_vld_next;
    logic [31:0]   sent_reg, sent_next;
    logic [31:0]   pong_reg, pong_next;
    logic [31:0]   fail_reg, fail_next;
    logic [31:0]   erx_reg,  erx_next;
    logic [31:0]   etx_reg,  etx_next;
    logic [31:0]   ign_reg,  ign_next;
    logic [31:0]   rlast_reg, rlast_next;
    logic [31:0]   rmin_reg,  rmin_next;
    logic [31:0]   rmax_reg,  rmax_next;
    logic [47:0]   rsum_reg,  rsum_next;
    logic [1:0]    tx_kind;
    logic [31:0]   tx_seq;
    logic          start_sweep;

    slot_t       slot;
    logic        match;
    logic [48:0] tick_diff;
    logic [48:0] rtt_diff;
    logic [31:0] r32;
    logic [48:0] sum_add;
    logic        bad_frame;
    logic [31:0] seq_inc;
    item_t       it;

    always_comb
    begin
        it        = s1_item_reg;
        slot      = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        match     = slot.used && (slot.seq == it.pkt_seq);
        tick_diff = {1'b0, it.now_us} - {1'b0, last_ping_reg};
        rtt_diff  = {1'b0, it.now_us} - {1'b0, slot.stamp};
        r32       = (|rtt_diff[47:32]) ? 32'hFFFF_FFFF : rtt_diff[31:0];
        sum_add   = {1'b0, rsum_reg} + {1'b0, rtt_diff[47:0]};
        bad_frame = !radio_ready_reg || !peer_valid_reg ||
                    (it.frame_len != FRAME_LEN_OK) || (it.src_addr != peer_addr_reg);
        seq_inc   = next_seq_reg + 32'd1;

        next_seq_next  = next_seq_reg;
        next_idx_next  = next_idx_reg;
        last_ping_next = last_ping_reg;
        last_vld_next  = last_vld_reg;
        sent_next      = sent_reg;
        pong_next      = pong_reg;
        fail_next      = fail_reg;
        erx_next       = erx_reg;
        etx_next       = etx_reg;
        ign_next       = ign_reg;
        rlast_next     = rlast_reg;
        rmin_next      = rmin_reg;
        rmax_next      = rmax_reg;
        rsum_next      = rsum_reg;
        tx_kind        = TX_NONE;
        tx_seq         = 32'd0;
        start_sweep    = 1'b0;
        s1_wr          = 1'b0;
        s1_wr_addr     = s1_idx_reg;
        s1_wr_data     = {1'b0, slot.seq, slot.stamp};

        case (it.func)
            FUNC_TICK:
            begin
                if (radio_ready_reg && running_reg && role_reg == ROLE_PING &&
                    peer_valid_reg &&
                    (!last_vld_reg || (!tick_diff[48] &&
                     tick_diff[47:0] >= 48'(ping_period_reg))))
                begin
                    last_ping_next = it.now_us;
                    last_vld_next  = 1'b1;
                    next_seq_next  = seq_inc;
                    next_idx_next  = (next_idx_reg == LAST_IDX) ? '0 :
                                     next_idx_reg + 1'b1;
                    s1_wr          = 1'b1;
                    s1_wr_addr     = next_idx_next;
                    s1_wr_data     = {1'b1, seq_inc, it.now_us};
                    tx_kind        = TX_PING;
                    tx_seq         = seq_inc;
                end
            end
            FUNC_FRAME:
            begin
                if (bad_frame)
                begin
                    ign_next = ign_reg + 32'd1;
                end
                else if (it.pkt_kind == KIND_PING && role_reg == ROLE_ECHO && running_reg)
                begin
                    erx_next = erx_reg + 32'd1;
                    tx_kind  = TX_PONG;
                    tx_seq   = it.pkt_seq;
                end
                else if (it.pkt_kind == KIND_PONG && role_reg == ROLE_PING && match)
                begin
                    // pong before its ping time frees the slot and counts the pong but skips the rtt stats
                    if (!rtt_diff[48])
                    begin
                        rlast_next = r32;
                        if (rmin_reg == 32'd0 || r32 < rmin_reg)
                        begin
                            rmin_next = r32;
                        end
                        if (r32 > rmax_reg)
                        begin
                            rmax_next = r32;
                        end
                        rsum_next = sum_add[48] ? 48'hFFFF_FFFF_FFFF : sum_add[47:0];
                    end
                    s1_wr     = 1'b1;
                    pong_next = pong_reg + 32'd1;
                end
            end
            FUNC_TXOUT:
            begin
                if (it.pkt_kind == KIND_PING)
                begin
                    if (it.ok)
                    begin
                        sent_next = sent_reg + 32'd1;
                    end
                    else
                    begin
                        fail_next = fail_reg + 32'd1;
                        s1_wr     = match;
                    end
                end
                else if (it.pkt_kind == KIND_PONG)
                begin
                    if (it.ok)
                    begin
                        etx_next = etx_reg + 32'd1;
                    end
                    else
                    begin
                        fail_next = fail_reg + 32'd1;
                    end
                end
            end
            FUNC_DELIV:
            begin
                if (!it.ok)
                begin
                    fail_next = fail_reg + 32'd1;
                end
            end
            FUNC_CLEAR:
            begin
                next_seq_next  = 32'd0;
                next_idx_next  = '0;
                last_ping_next = 48'd0;
                last_vld_next  = 1'b0;
                sent_next      = 32'd0;
                pong_next      = 32'd0;
                fail_next      = 32'd0;
                erx_next       = 32'd0;
                etx_next       = 32'd0;
                ign_next       = 32'd0;
                rlast_next     = 32'd0;
                rmin_next      = 32'd0;
                rmax_next      = 32'd0;
                rsum_next      = 48'd0;
                start_sweep    = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            next_seq_reg  <= 32'd0;
            next_idx_reg  <= '0;
            last_ping_reg <= 48'd0;
            last_vld_reg  <= 1'b0;
            sent_reg      <= 32'd0;
            pong_reg      <= 32'd0;
            fail_reg      <= 32'd0;
            erx_reg       <= 32'd0;
            etx_reg       <= 32'd0;
            ign_reg       <= 32'd0;
            rlast_reg     <= 32'd0;
            rmin_reg      <= 32'd0;
            rmax_reg      <= 32'd0;
            rsum_reg      <= 48'd0;
        end
        else
        begin
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (s0_move)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (s0_move)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (wr_addr == rd_idx);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (sweep_reg)
            begin
                sweep_idx_reg <= (sweep_idx_reg == LAST_IDX) ? '0 : sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == LAST_IDX)
                begin
                    sweep_reg <= 1'b0;
                end
            end
            else if (s1_adv && start_sweep)
            begin
                sweep_reg     <= 1'b1;
                sweep_idx_reg <= '0;
            end

            if (s1_adv)
            begin
                next_seq_reg  <= next_seq_next;
                next_idx_reg  <= next_idx_next;
                last_ping_reg <= last_ping_next;
                last_vld_reg  <= last_vld_next;
                sent_reg      <= sent_next;
                pong_reg      <= pong_next;
                fail_reg      <= fail_next;
                erx_reg       <= erx_next;
                etx_reg       <= etx_next;
                ign_reg       <= ign_next;
                rlast_reg     <= rlast_next;
                rmin_reg      <= rmin_next;
                rmax_reg      <= rmax_next;
                rsum_reg      <= rsum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_item_reg <= item;
            s0_q_reg    <= prod[32 + AW +: AW + 1];
        end
        if (s0_move)
        begin
            s1_item_reg <= s0_item_reg;
        end
        if (s1_adv)
        begin
            out_reg.tx_kind       <= tx_kind;
            out_reg.tx_seq        <= tx_seq;
            out_reg.sent_count    <= sent_next;
            out_reg.pong_count    <= pong_next;
            out_reg.fail_count    <= fail_next;
            out_reg.echo_rx_count <= erx_next;
            out_reg.echo_tx_count <= etx_next;
            out_reg.ignored_count <= ign_next;
            out_reg.rtt_last      <= rlast_next;
            out_reg.rtt_min       <= rmin_next;
            out_reg.rtt_max       <= rmax_next;
            out_reg.rtt_sum       <= rsum_next;
        end
    end

    // ---------------- assertions ----------------
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> (!item_ready && !s0_move))
        else $error("word taken or slot read during table sweep");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.func == FUNC_CLEAR) |-> !item_ready)
        else $error("word accepted behind a clear");

    a_rtt_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rmin_reg != 32'd0) |-> (rmin_reg <= rmax_reg))
        else $error("rtt min above rtt max");

    a_sweep_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_item_reg.func == FUNC_CLEAR) |=> sweep_reg)
        else $error("clear did not start the table sweep");

    a_ping_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && tx_kind == TX_PING) |=> (out_reg.tx_seq == next_seq_reg))
        else $error("ping sequence out of step with counter");

endmodule
